/* rtl/pid_controller_step_core_defines.svh */
// Assertion macros shared by the PID controller step RTL.
// Needs a clock named clock and an active-high reset named reset in scope.
`ifndef PID_CONTROLLER_STEP_CORE_DEFINES_SVH
`define PID_CONTROLLER_STEP_CORE_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define PCS_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("pcs assertion failed (same cycle)");

// Check that a condition implies another in the next cycle
`define PCS_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("pcs assertion failed (next cycle)");

`endif

/* rtl/pcs_pkg.sv */
// Shared widths, register indexes, step codes and command type for the PID step core.
// No dependencies.
`default_nettype none

package pcs_pkg;

   // Field widths
   localparam int ERR_W     = 16;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 3;
   localparam int DRIVE_W   = 32;
   localparam int INTEG_W   = 40;
   localparam int SLOPE_W   = 24;

   // Shared multiplier and accumulator widths
   localparam int MUL_A_W   = 17;
   localparam int MUL_B_W   = 25;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int SUM_W     = 58;

   // Fixed-point alignment
   localparam int INTEG_SPLIT = 20;  // integral split point for the two partial products
   localparam int FRAC_Q12    = 12;  // Q.8 gain times integer term -> Q.20
   localparam int SLOPE_SHIFT = 8;   // Q.8 slope product -> integer
   localparam int DRIVE_SHIFT = 20;  // Q.20 sum -> integer drive

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_TIME = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_RATE = 3'd4;

   localparam logic [CSR_W-1:0] STEP_TIME_RESET = 16'd4096;
   localparam logic [CSR_W-1:0] STEP_RATE_RESET = 16'd256;

   // Datapath step codes
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_NONE   = 3'd0;
   localparam logic [OP_W-1:0] OP_INTEG  = 3'd1;  // mul err*dt
   localparam logic [OP_W-1:0] OP_DERIV  = 3'd2;  // update integral, mul diff*rate
   localparam logic [OP_W-1:0] OP_PROP   = 3'd3;  // form slope, mul kp*err
   localparam logic [OP_W-1:0] OP_ILO    = 3'd4;  // start sum, mul ki*integral low
   localparam logic [OP_W-1:0] OP_IHI    = 3'd5;  // add, mul ki*integral high
   localparam logic [OP_W-1:0] OP_DSLOPE = 3'd6;  // add, mul kd*slope
   localparam logic [OP_W-1:0] OP_FINAL  = 3'd7;  // add last product

   typedef struct packed {
      logic            take;      // capture the incoming error sample
      logic [OP_W-1:0] op;        // datapath step for this cycle
      logic            load_out;  // load the result registers
   } pcs_cmd_type;

endpackage

`default_nettype wire

/* rtl/pcs_ctrl.sv */
// Sequencer for the PID step core: walks one transaction through the shared multiplier.
// Depends on pcs_pkg.
`default_nettype none

module pcs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output pcs_pkg::pcs_cmd_type cmd
);
   import pcs_pkg::*;

   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] S_IDLE   = 4'd0;
   localparam logic [ST_W-1:0] S_INTEG  = 4'd1;
   localparam logic [ST_W-1:0] S_DERIV  = 4'd2;
   localparam logic [ST_W-1:0] S_PROP   = 4'd3;
   localparam logic [ST_W-1:0] S_ILO    = 4'd4;
   localparam logic [ST_W-1:0] S_IHI    = 4'd5;
   localparam logic [ST_W-1:0] S_DSLOPE = 4'd6;
   localparam logic [ST_W-1:0] S_FINAL  = 4'd7;
   localparam logic [ST_W-1:0] S_OUT    = 4'd8;

   logic [ST_W-1:0] state_ff, state_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Advance through the steps; hold in S_OUT while the result slot is full
   always_comb begin
      state_in     = state_ff;
      cmd.take     = 1'b0;
      cmd.op       = OP_NONE;
      cmd.load_out = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.take = req_valid;
            if (req_valid) state_in = S_INTEG;
         end
         S_INTEG: begin
            cmd.op   = OP_INTEG;
            state_in = S_DERIV;
         end
         S_DERIV: begin
            cmd.op   = OP_DERIV;
            state_in = S_PROP;
         end
         S_PROP: begin
            cmd.op   = OP_PROP;
            state_in = S_ILO;
         end
         S_ILO: begin
            cmd.op   = OP_ILO;
            state_in = S_IHI;
         end
         S_IHI: begin
            cmd.op   = OP_IHI;
            state_in = S_DSLOPE;
         end
         S_DSLOPE: begin
            cmd.op   = OP_DSLOPE;
            state_in = S_FINAL;
         end
         S_FINAL: begin
            cmd.op   = OP_FINAL;
            state_in = S_OUT;
         end
         S_OUT: begin
            cmd.load_out = out_free;
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Result valid: set on load, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/pcs_datapath.sv */
// Datapath for the PID step core: config registers, state, shared multiplier,
// accumulator and result registers. Depends on pcs_pkg.
`default_nettype none

module pcs_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  pcs_pkg::pcs_cmd_type                   cmd,
   input  logic                                   csr_we,
   input  logic        [pcs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic        [pcs_pkg::CSR_W-1:0]       csr_wdata,
   input  logic signed [pcs_pkg::ERR_W-1:0]       req_error_sample,
   output logic signed [pcs_pkg::DRIVE_W-1:0]     rsp_drive,
   output logic                                   rsp_clipped,
   output logic signed [pcs_pkg::INTEG_W-1:0]     rsp_integral_now,
   output logic signed [pcs_pkg::SLOPE_W-1:0]     rsp_slope_now
);
   import pcs_pkg::*;

   localparam int INTEG_HI_W = INTEG_W - INTEG_SPLIT;

   // Configuration registers
   logic [CSR_W-1:0] gain_p_ff, gain_i_ff, gain_d_ff, step_time_ff, step_rate_ff;

   // Controller state and per-transaction working registers
   logic signed [INTEG_W-1:0] acc_ff,   acc_in;
   logic signed [ERR_W-1:0]   prior_ff;
   logic signed [ERR_W-1:0]   err_ff;
   logic signed [SLOPE_W-1:0] slope_ff, slope_in;
   logic                      sat_ff;
   logic signed [PROD_W-1:0]  prod_ff,  prod_in;
   logic signed [SUM_W-1:0]   sum_ff,   sum_in;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_A_W-1:0] err_diff;
   logic signed [SUM_W-1:0]   prod_ext;

   logic signed [INTEG_W:0]   integ_sum;
   logic                      integ_ovf;
   logic signed [PROD_W-1:0]  slope_q;
   logic                      slope_ovf;
   logic signed [SUM_W-1:0]   drive_q;
   logic                      drive_ovf;
   logic signed [DRIVE_W-1:0] drive_in;

   // Write configuration registers; drop writes beyond the list
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff    <= '0;
         gain_i_ff    <= '0;
         gain_d_ff    <= '0;
         step_time_ff <= STEP_TIME_RESET;
         step_rate_ff <= STEP_RATE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GAIN_P:    gain_p_ff    <= csr_wdata;
            CSR_GAIN_I:    gain_i_ff    <= csr_wdata;
            CSR_GAIN_D:    gain_d_ff    <= csr_wdata;
            CSR_STEP_TIME: step_time_ff <= csr_wdata;
            CSR_STEP_RATE: step_rate_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign err_diff = {err_ff[ERR_W-1], err_ff} - {prior_ff[ERR_W-1], prior_ff};

   // Select multiplier operands for this step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         OP_INTEG: begin
            mul_a = {err_ff[ERR_W-1], err_ff};
            mul_b = {{(MUL_B_W-CSR_W){1'b0}}, step_time_ff};
         end
         OP_DERIV: begin
            mul_a = err_diff;
            mul_b = {{(MUL_B_W-CSR_W){1'b0}}, step_rate_ff};
         end
         OP_PROP: begin
            mul_a = {gain_p_ff[CSR_W-1], gain_p_ff};
            mul_b = {{(MUL_B_W-ERR_W){err_ff[ERR_W-1]}}, err_ff};
         end
         OP_ILO: begin
            mul_a = {gain_i_ff[CSR_W-1], gain_i_ff};
            mul_b = {{(MUL_B_W-INTEG_SPLIT){1'b0}}, acc_ff[INTEG_SPLIT-1:0]};
         end
         OP_IHI: begin
            mul_a = {gain_i_ff[CSR_W-1], gain_i_ff};
            mul_b = {{(MUL_B_W-INTEG_HI_W){acc_ff[INTEG_W-1]}},
                     acc_ff[INTEG_W-1:INTEG_SPLIT]};
         end
         OP_DSLOPE: begin
            mul_a = {gain_d_ff[CSR_W-1], gain_d_ff};
            mul_b = {{(MUL_B_W-SLOPE_W){slope_ff[SLOPE_W-1]}}, slope_ff};
         end
         OP_NONE, OP_FINAL: begin
            mul_a = '0;
            mul_b = '0;
         end
         default: ;
      endcase
   end

   assign prod_in  = mul_a * mul_b;
   assign prod_ext = {{(SUM_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   // Saturating integral update from err*dt
   assign integ_sum = {acc_ff[INTEG_W-1], acc_ff} + (INTEG_W+1)'(prod_ff);
   assign integ_ovf = (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]);
   always_comb begin
      if (integ_ovf) acc_in = {integ_sum[INTEG_W], {(INTEG_W-1){!integ_sum[INTEG_W]}}};
      else           acc_in = integ_sum[INTEG_W-1:0];
   end

   // Slope: divide the Q.8 product by 256 toward zero, then clamp
   assign slope_q   = (prod_ff >>> SLOPE_SHIFT)
                    + $signed(PROD_W'(prod_ff[PROD_W-1] && (|prod_ff[SLOPE_SHIFT-1:0])));
   assign slope_ovf = (slope_q[PROD_W-1:SLOPE_W-1]
                       != {(PROD_W-SLOPE_W+1){slope_q[PROD_W-1]}});
   always_comb begin
      if (slope_ovf) slope_in = {slope_q[PROD_W-1], {(SLOPE_W-1){!slope_q[PROD_W-1]}}};
      else           slope_in = slope_q[SLOPE_W-1:0];
   end

   // Accumulate the Q.20 drive sum
   always_comb begin
      sum_in = sum_ff;
      unique case (cmd.op)
         OP_ILO:    sum_in = prod_ext <<< FRAC_Q12;
         OP_IHI:    sum_in = sum_ff + prod_ext;
         OP_DSLOPE: sum_in = sum_ff + (prod_ext <<< INTEG_SPLIT);
         OP_FINAL:  sum_in = sum_ff + (prod_ext <<< FRAC_Q12);
         OP_NONE, OP_INTEG, OP_DERIV, OP_PROP: sum_in = sum_ff;
         default: ;
      endcase
   end

   // Drive: divide by 2^20 toward zero, clamp to 32 bits
   assign drive_q   = (sum_ff >>> DRIVE_SHIFT)
                    + $signed(SUM_W'(sum_ff[SUM_W-1] && (|sum_ff[DRIVE_SHIFT-1:0])));
   assign drive_ovf = (drive_q[SUM_W-1:DRIVE_W-1]
                       != {(SUM_W-DRIVE_W+1){drive_q[SUM_W-1]}});
   always_comb begin
      if (drive_ovf) drive_in = {drive_q[SUM_W-1], {(DRIVE_W-1){!drive_q[SUM_W-1]}}};
      else           drive_in = drive_q[DRIVE_W-1:0];
   end

   // Controller state: integral and previous error
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         prior_ff <= '0;
      end else begin
         if (cmd.op == OP_DERIV) acc_ff   <= acc_in;
         if (cmd.op == OP_PROP)  prior_ff <= err_ff;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (cmd.take)           err_ff   <= req_error_sample;
      if (cmd.op == OP_DERIV) sat_ff   <= integ_ovf;
      if (cmd.op == OP_PROP)  slope_ff <= slope_in;
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
   end

   // Result registers
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_drive        <= drive_in;
         rsp_clipped      <= sat_ff || drive_ovf;
         rsp_integral_now <= acc_ff;
         rsp_slope_now    <= slope_ff;
      end
   end

endmodule

`default_nettype wire

/* rtl/pid_controller_step_core.sv */
// PID controller step: top level joining the sequencer and the datapath.
// Depends on pcs_pkg, pcs_ctrl, pcs_datapath and pid_controller_step_core_defines.svh.
//
// Usage:
//  - req channel: one signed 16-bit error sample per transaction (valid/ready).
//  - rsp channel: drive, clipped flag, new integral (Q28.12) and slope per transaction.
//  - csr port: write gains (Q8.8), step time (Q4.12) and step rate (Q8.8) by index
//    while the core is idle; writes to unused indexes are dropped.
//  - An accepted request walks the sequencer through S_INTEG, S_DERIV, S_PROP,
//    S_ILO, S_IHI, S_DSLOPE, S_FINAL and S_OUT; a single 17x25 multiplier is
//    shared over six products, one per cycle, then S_FINAL adds the last
//    product and S_OUT loads the result; the idle state takes the next request.
//  - The result sits in an output register, so the next request is taken while
//    the previous result still waits; a stalled receiver holds the core only
//    when a finished result finds the output register still full.
//  - Reset (synchronous): clears the integral and previous error, sets gains to
//    zero, step time to 1.0 and step rate to 1.0, and drops any pending result.
`default_nettype none

module pid_controller_step_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [pcs_pkg::ERR_W-1:0]      req_error_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [pcs_pkg::DRIVE_W-1:0]    rsp_drive,
   output logic                                  rsp_clipped,
   output logic signed [pcs_pkg::INTEG_W-1:0]    rsp_integral_now,
   output logic signed [pcs_pkg::SLOPE_W-1:0]    rsp_slope_now,
   input  logic                                  csr_we,
   input  logic        [pcs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic        [pcs_pkg::CSR_W-1:0]      csr_wdata
);
   import pcs_pkg::*;

`include "pid_controller_step_core_defines.svh"

   pcs_cmd_type cmd;

   pcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   pcs_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_error_sample (req_error_sample),
      .rsp_drive        (rsp_drive),
      .rsp_clipped      (rsp_clipped),
      .rsp_integral_now (rsp_integral_now),
      .rsp_slope_now    (rsp_slope_now)
   );

   // One transaction in flight at a time
   `PCS_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)
   // Never overwrite a result that the receiver has not taken
   `PCS_ASSERT_NOW(a_no_overwrite, rsp_valid && !rsp_ready, !cmd.load_out)
   // A loaded result is presented in the next cycle
   `PCS_ASSERT_NEXT(a_load_presents, cmd.load_out, rsp_valid)

endmodule

`default_nettype wire
